// ===== rtl/spiral_scan_coordinate_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Spiral scan generator assertion macros
// Shared concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SPIRAL_SCAN_COORDINATE_GENERATOR_DEFINES_SVH
`define SPIRAL_SCAN_COORDINATE_GENERATOR_DEFINES_SVH

`ifndef SYNTH
// Condition must hold at every clock edge out of reset.
`define SSCG_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);
// Consequent must hold at the clock edge after the antecedent.
`define SSCG_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SSCG_ASSERT_ALWAYS(label, cond, msg)
`define SSCG_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ===== rtl/sscg_pkg.sv =====
// ----------------------------------------------------------------------------
// Spiral scan generator package
// Heading type, register map and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package sscg_pkg;

    typedef enum logic [1:0] {
        HEAD_UP    = 2'd0,
        HEAD_RIGHT = 2'd1,
        HEAD_DOWN  = 2'd2,
        HEAD_LEFT  = 2'd3
    } t_heading;

    localparam int CFG_BITS  = 12;
    localparam int ROT_BITS  = 15;
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;

    localparam logic REG_LAST_X = 1'b0;
    localparam logic REG_LAST_Y = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/sscg_start.sv =====
// ----------------------------------------------------------------------------
// Spiral start point
// Derives start position, heading and bounds from the canvas extents.
// ----------------------------------------------------------------------------
`default_nettype none

module sscg_start #(
    parameter int COORD_BITS = 12
) (
    input  wire logic [sscg_pkg::CFG_BITS-1:0] i_last_x,
    input  wire logic [sscg_pkg::CFG_BITS-1:0] i_last_y,
    output logic [COORD_BITS+1:0]              o_cur_x,
    output logic [COORD_BITS+1:0]              o_cur_y,
    output sscg_pkg::t_heading                 o_heading,
    output logic [COORD_BITS+1:0]              o_bound_up,
    output logic [COORD_BITS+1:0]              o_bound_down,
    output logic [COORD_BITS+1:0]              o_bound_left,
    output logic [COORD_BITS+1:0]              o_bound_right
);
    import sscg_pkg::*;

    localparam int W = COORD_BITS + 2;
    localparam logic [W-1:0] MASK = W'({COORD_BITS{1'b1}});
    localparam logic [W-1:0] ONE  = W'(1);
    localparam logic [W-1:0] TWO  = W'(2);

    logic [W-1:0] x, y, s, diff, h, dx, dy;
    logic         gt, ge, odd;

    always_comb begin
        x    = W'(i_last_x) & MASK;
        y    = W'(i_last_y) & MASK;
        gt   = (x > y);
        ge   = (x >= y);
        s    = ge ? y : x;
        diff = ge ? (x - y) : (y - x);
        h    = s >> 1;
        odd  = s[0];
        dx   = gt ? diff : '0;
        dy   = gt ? '0 : diff;
    end

    // Heading follows short-side parity and whether the canvas is wider than tall.
    always_comb begin
        if (odd) begin
            o_heading = gt ? HEAD_RIGHT : HEAD_DOWN;
        end else begin
            o_heading = gt ? HEAD_LEFT : HEAD_UP;
        end
    end

    always_comb begin
        o_bound_up    = h - ONE;
        o_bound_down  = h + ONE + dy;
        o_bound_left  = (odd || gt) ? h : (h - ONE);
        o_bound_right = (odd && !gt) ? (h + TWO) : (h + ONE + dx);
    end

    // Start point already backed off one place against the heading.
    always_comb begin
        case (o_heading)
            HEAD_UP: begin
                o_cur_x = h;
                o_cur_y = h + ONE + diff;
            end
            HEAD_LEFT: begin
                o_cur_x = h + diff + ONE;
                o_cur_y = h;
            end
            HEAD_DOWN: begin
                o_cur_x = h + ONE;
                o_cur_y = h - ONE;
            end
            default: begin
                o_cur_x = h;
                o_cur_y = h;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sscg_step.sv =====
// ----------------------------------------------------------------------------
// Spiral single step
// Moves one place along the heading and turns right on meeting a bound.
// ----------------------------------------------------------------------------
`default_nettype none

module sscg_step #(
    parameter int COORD_BITS = 12
) (
    input  wire logic [COORD_BITS+1:0] i_cur_x,
    input  wire logic [COORD_BITS+1:0] i_cur_y,
    input  sscg_pkg::t_heading         i_heading,
    input  wire logic [COORD_BITS+1:0] i_bound_up,
    input  wire logic [COORD_BITS+1:0] i_bound_down,
    input  wire logic [COORD_BITS+1:0] i_bound_left,
    input  wire logic [COORD_BITS+1:0] i_bound_right,
    output logic [COORD_BITS+1:0]      o_cur_x,
    output logic [COORD_BITS+1:0]      o_cur_y,
    output sscg_pkg::t_heading         o_heading,
    output logic [COORD_BITS+1:0]      o_bound_up,
    output logic [COORD_BITS+1:0]      o_bound_down,
    output logic [COORD_BITS+1:0]      o_bound_left,
    output logic [COORD_BITS+1:0]      o_bound_right
);
    import sscg_pkg::*;

    localparam int W = COORD_BITS + 2;
    localparam logic [W-1:0] ONE = W'(1);

    logic [W-1:0] x_inc, x_dec, y_inc, y_dec;

    assign x_inc = i_cur_x + ONE;
    assign x_dec = i_cur_x - ONE;
    assign y_inc = i_cur_y + ONE;
    assign y_dec = i_cur_y - ONE;

    // Position update.
    always_comb begin
        o_cur_x = i_cur_x;
        o_cur_y = i_cur_y;
        case (i_heading)
            HEAD_UP:    o_cur_y = y_dec;
            HEAD_RIGHT: o_cur_x = x_inc;
            HEAD_DOWN:  o_cur_y = y_inc;
            default:    o_cur_x = x_dec;
        endcase
    end

    // Turn and push the bound that was met one place outwards.
    always_comb begin
        o_heading     = i_heading;
        o_bound_up    = i_bound_up;
        o_bound_down  = i_bound_down;
        o_bound_left  = i_bound_left;
        o_bound_right = i_bound_right;
        case (i_heading)
            HEAD_UP: begin
                if (y_dec == i_bound_up) begin
                    o_heading  = HEAD_RIGHT;
                    o_bound_up = i_bound_up - ONE;
                end
            end
            HEAD_RIGHT: begin
                if (x_inc == i_bound_right) begin
                    o_heading     = HEAD_DOWN;
                    o_bound_right = i_bound_right + ONE;
                end
            end
            HEAD_DOWN: begin
                if (y_inc == i_bound_down) begin
                    o_heading    = HEAD_LEFT;
                    o_bound_down = i_bound_down + ONE;
                end
            end
            default: begin
                if (x_dec == i_bound_left) begin
                    o_heading    = HEAD_UP;
                    o_bound_left = i_bound_left - ONE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/spiral_scan_coordinate_generator.sv =====
// ----------------------------------------------------------------------------
// Spiral scan coordinate generator
// Walks a canvas from the center outwards in spiral order, one coordinate
// per input beat, ending at the corner (0,0).
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  -------------------------------
//   in       sink       i_in_valid / o_in_stall   i_restart
//   out      source     o_out_valid / i_out_stall o_pos_x o_pos_y
//                                                 o_rotation_steps o_at_end
//                                                 o_overrun
//   cfg      APB        psel penable pwrite       paddr pwdata prdata pready
//
// One beat per cycle while o_in_stall is low: the walk state registers update
// at the edge that accepts an input beat and the result shows on the next
// cycle. The walk state itself is the result register; outputs decode it.
// o_in_stall rises only while a result is held by i_out_stall.
// Synchronous active-low reset loads the start state for a one-point canvas.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spiral_scan_coordinate_generator_defines.svh"

module spiral_scan_coordinate_generator #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_restart,

    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [COORD_BITS-1:0]                  o_pos_x,
    output logic [COORD_BITS-1:0]                  o_pos_y,
    output logic [sscg_pkg::ROT_BITS-1:0]          o_rotation_steps,
    output logic                                   o_at_end,
    output logic                                   o_overrun,

    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sscg_pkg::ADDR_BITS-1:0]    paddr,
    input  wire logic [sscg_pkg::DATA_BITS-1:0]    pwdata,
    output logic [sscg_pkg::DATA_BITS-1:0]         prdata,
    output logic                                   pready
);
    import sscg_pkg::*;

    localparam int W  = COORD_BITS + 2;
    localparam int RW = (W + 3 > ROT_BITS) ? (W + 3) : ROT_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_BITS-1:0] r_last_x, r_last_y;
    logic                w_cfg_wr;
    logic                w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= '0;
            r_last_y <= '0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_LAST_X: r_last_x <= pwdata[CFG_BITS-1:0];
                REG_LAST_Y: r_last_y <= pwdata[CFG_BITS-1:0];
                default:    r_last_x <= r_last_x;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_LAST_X: prdata = DATA_BITS'(r_last_x);
            REG_LAST_Y: prdata = DATA_BITS'(r_last_y);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: the walk state advances only on an accepted input beat,
    // and that beat can only land when no result is held or the held one is leaving.
    // ------------------------------------------------------------------
    logic r_out_valid, r_overrun;
    logic w_in_acc;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------------
    // Walk state
    // ------------------------------------------------------------------
    logic [W-1:0] r_cur_x, r_cur_y, r_bu, r_bd, r_bl, r_br;
    t_heading     r_heading;

    logic [W-1:0] st_x, st_y, st_bu, st_bd, st_bl, st_br;
    t_heading     st_heading;

    logic [W-1:0] sel_x, sel_y, sel_bu, sel_bd, sel_bl, sel_br;
    t_heading     sel_heading;

    logic [W-1:0] stp_x, stp_y, stp_bu, stp_bd, stp_bl, stp_br;
    t_heading     stp_heading;

    logic [W-1:0] n_cur_x, n_cur_y, n_bu, n_bd, n_bl, n_br;
    t_heading     n_heading;
    logic         n_overrun;
    logic         w_sel_end;

    sscg_start #(
        .COORD_BITS (COORD_BITS)
    ) u_start (
        .i_last_x      (r_last_x),
        .i_last_y      (r_last_y),
        .o_cur_x       (st_x),
        .o_cur_y       (st_y),
        .o_heading     (st_heading),
        .o_bound_up    (st_bu),
        .o_bound_down  (st_bd),
        .o_bound_left  (st_bl),
        .o_bound_right (st_br)
    );

    // Restart loads the start state first; the step then applies to it.
    always_comb begin
        if (i_restart) begin
            sel_x = st_x;   sel_y = st_y;   sel_heading = st_heading;
            sel_bu = st_bu; sel_bd = st_bd; sel_bl = st_bl; sel_br = st_br;
        end else begin
            sel_x = r_cur_x; sel_y = r_cur_y; sel_heading = r_heading;
            sel_bu = r_bu;   sel_bd = r_bd;   sel_bl = r_bl; sel_br = r_br;
        end
    end

    sscg_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_cur_x       (sel_x),
        .i_cur_y       (sel_y),
        .i_heading     (sel_heading),
        .i_bound_up    (sel_bu),
        .i_bound_down  (sel_bd),
        .i_bound_left  (sel_bl),
        .i_bound_right (sel_br),
        .o_cur_x       (stp_x),
        .o_cur_y       (stp_y),
        .o_heading     (stp_heading),
        .o_bound_up    (stp_bu),
        .o_bound_down  (stp_bd),
        .o_bound_left  (stp_bl),
        .o_bound_right (stp_br)
    );

    assign w_sel_end = (sel_x == '0) && (sel_y == '0);

    // Hold everything once the end corner is reached; flag the overrun.
    always_comb begin
        n_overrun = w_sel_end;
        if (w_sel_end) begin
            n_cur_x = sel_x;   n_cur_y = sel_y;   n_heading = sel_heading;
            n_bu = sel_bu;     n_bd = sel_bd;     n_bl = sel_bl;  n_br = sel_br;
        end else begin
            n_cur_x = stp_x;   n_cur_y = stp_y;   n_heading = stp_heading;
            n_bu = stp_bu;     n_bd = stp_bd;     n_bl = stp_bl;  n_br = stp_br;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_overrun   <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= W'(1);
            r_heading   <= HEAD_UP;
            r_bu        <= '1;
            r_bd        <= W'(1);
            r_bl        <= '1;
            r_br        <= W'(1);
        end else begin
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
                r_overrun   <= n_overrun;
                r_cur_x     <= n_cur_x;
                r_cur_y     <= n_cur_y;
                r_heading   <= n_heading;
                r_bu        <= n_bu;
                r_bd        <= n_bd;
                r_bl        <= n_bl;
                r_br        <= n_br;
            end else if (!i_out_stall) begin
                // drop the result once it has been taken
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result decode from the walk state
    // ------------------------------------------------------------------
    logic signed [RW-1:0] w_span;
    logic        [RW-1:0] w_rot;
    logic                 w_cur_end;

    assign w_span = RW'($signed(r_br)) - RW'($signed(r_bl))
                  + RW'($signed(r_bd)) - RW'($signed(r_bu));
    assign w_rot  = RW'(w_span <<< 1) - RW'(1);

    assign w_cur_end        = (r_cur_x == '0) && (r_cur_y == '0);
    assign o_pos_x          = r_cur_x[COORD_BITS-1:0];
    assign o_pos_y          = r_cur_y[COORD_BITS-1:0];
    assign o_rotation_steps = w_rot[ROT_BITS-1:0];
    assign o_at_end         = w_cur_end;
    assign o_overrun        = r_overrun;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SSCG_ASSERT_ALWAYS(a_overrun_at_end, !(r_out_valid && r_overrun) || w_cur_end, "overrun away from end corner")
    `SSCG_ASSERT_NEXT(a_single_axis_move, w_in_acc && !i_restart && !w_cur_end, (r_cur_x != $past(r_cur_x)) ^ (r_cur_y != $past(r_cur_y)), "step did not move exactly one axis")
    `SSCG_ASSERT_NEXT(a_end_hold, w_in_acc && !i_restart && w_cur_end, $stable(r_cur_x) && $stable(r_cur_y) && r_overrun, "position moved past end corner")

endmodule

`default_nettype wire
